[rtl/assert_macros.svh]
// Assertion macros used by the checker module ctcc_checker.
// Clock i_clk and active-low reset i_rst_n must exist where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, active during reset as well.
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/ctcc_pkg.sv]
// Package for the cold tank chill controller: types, register indexes, reset values.
// Used by ctcc_step and cold_tank_chill_control_core.
`timescale 1ns / 1ps

package ctcc_pkg;

    localparam int CHECK_TICKS_DEF = 60;

    localparam int TEMP_W  = 12;
    localparam int TICKS_W = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAKE_ENABLE  = 3'd0,
        CFG_ON_TEMP      = 3'd1,
        CFG_OFF_TEMP     = 3'd2,
        CFG_PROTECT_TEMP = 3'd3,
        CFG_HOT_THRESH   = 3'd4,
        CFG_WARM_THRESH  = 3'd5,
        CFG_LONG_TICKS   = 3'd6,
        CFG_SHORT_TICKS  = 3'd7
    } t_cfg_idx;

    localparam logic                     MAKE_ENABLE_RST  = 1'b1;
    localparam logic signed [TEMP_W-1:0] ON_TEMP_RST      = 12'sd68;
    localparam logic signed [TEMP_W-1:0] OFF_TEMP_RST     = 12'sd45;
    localparam logic signed [TEMP_W-1:0] PROTECT_TEMP_RST = 12'sd0;
    localparam logic signed [TEMP_W-1:0] HOT_THRESH_RST   = 12'sd300;
    localparam logic signed [TEMP_W-1:0] WARM_THRESH_RST  = 12'sd150;
    localparam logic [TICKS_W-1:0]       LONG_TICKS_RST   = 12'd1020;
    localparam logic [TICKS_W-1:0]       SHORT_TICKS_RST  = 12'd540;

    typedef struct packed {
        logic                     make_enable;
        logic signed [TEMP_W-1:0] on_temp;
        logic signed [TEMP_W-1:0] off_temp;
        logic signed [TEMP_W-1:0] protect_temp;
        logic signed [TEMP_W-1:0] hot_threshold;
        logic signed [TEMP_W-1:0] warm_threshold;
        logic [TICKS_W-1:0]       long_extra_ticks;
        logic [TICKS_W-1:0]       short_extra_ticks;
    } t_cfg;

    // Laid out to match the input tdata: temperature in the lowest bits.
    typedef struct packed {
        logic                     cold_error;
        logic                     second_on_time_over;
        logic                     on_time_over;
        logic                     protect_time_expired;
        logic                     level_full;
        logic                     compressor_running;
        logic signed [TEMP_W-1:0] temperature;
    } t_sample;

    typedef struct packed {
        logic               making;
        logic               extra_phase;
        logic [TICKS_W-1:0] extra_count;
        logic               filled_flag;
    } t_state;

endpackage

[rtl/ctcc_step.sv]
// One-tick state update of the chill controller: level, countdown, hysteresis, veto.
// Depends on ctcc_pkg.
`timescale 1ns / 1ps

module ctcc_step #(
    parameter int CHECK_TICKS = ctcc_pkg::CHECK_TICKS_DEF,
    localparam int CNT_W = $clog2(CHECK_TICKS + 2)
) (
    input  ctcc_pkg::t_cfg    i_cfg,
    input  ctcc_pkg::t_sample i_sample,
    input  ctcc_pkg::t_state  i_state,
    input  logic [CNT_W-1:0]  i_check_cnt,
    output ctcc_pkg::t_state  o_state,
    output logic [CNT_W-1:0]  o_check_cnt
);

    localparam logic [CNT_W-1:0] CHECK_LIM = CNT_W'(CHECK_TICKS);

    always_comb begin
        logic                          mk;
        logic                          xp;
        logic [ctcc_pkg::TICKS_W-1:0]  ec;
        logic [CNT_W-1:0]              cc;
        logic                          veto;

        xp = i_state.extra_phase;
        ec = i_state.extra_count;
        cc = i_check_cnt;

        if (i_sample.compressor_running && xp) begin
            if (ec != '0) begin
                ec = ec - 1'b1;
            end else begin
                cc = '0;
            end
        end

        mk = xp ? 1'b0 : i_state.making;

        if (mk) begin
            if (i_cfg.off_temp >= i_sample.temperature) begin
                xp = 1'b1;
                mk = 1'b0;
            end
            priority if (cc < CHECK_LIM) begin
                cc = cc + 1'b1;
            end else if (cc == CHECK_LIM) begin
                cc = cc + 1'b1;
                priority if (i_sample.temperature > i_cfg.hot_threshold) begin
                    ec = i_cfg.long_extra_ticks;
                end else if (i_sample.temperature > i_cfg.warm_threshold) begin
                    ec = i_cfg.short_extra_ticks;
                end else begin
                    ec = '0;
                end
            end
        end else if (i_cfg.on_temp <= i_sample.temperature) begin
            mk = 1'b1;
        end

        if (ec != '0) begin
            mk = 1'b1;
            if (i_sample.temperature <= i_cfg.protect_temp) begin
                mk = 1'b0;
                ec = '0;
                cc = '0;
            end
        end else begin
            xp = 1'b0;
        end

        veto = !i_cfg.make_enable || !(i_state.filled_flag || i_sample.level_full)
            || !i_sample.protect_time_expired || i_sample.on_time_over
            || i_sample.second_on_time_over || i_sample.cold_error;
        if (veto) begin
            mk = 1'b0;
            ec = '0;
            cc = '0;
        end

        o_state.making      = mk;
        o_state.extra_phase = xp;
        o_state.extra_count = ec;
        o_state.filled_flag = i_state.filled_flag || i_sample.level_full;
        o_check_cnt         = cc;
    end

endmodule

[rtl/cold_tank_chill_control_core.sv]
// Top level of the cold tank chill controller: stream ports, config registers, state.
// Depends on ctcc_pkg and ctcc_step.
`timescale 1ns / 1ps

// One sample in, one decision out, per transfer. A sample is taken every cycle while the
// output is not stalled; its result is registered through the input register, then the result
// register, with the single state update in ctcc_step between the two registers. Each result
// shows the controller state after that sample. Config writes apply at once and are meant
// for idle periods only.
module cold_tank_chill_control_core #(
    parameter int CHECK_TICKS = ctcc_pkg::CHECK_TICKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [11:0] temperature, [12] compressor_running, [13] level_full,
    // [14] protect_time_expired, [15] on_time_over, [16] second_on_time_over,
    // [17] cold_error, [23:18] zero
    input  logic [23:0]                     i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [0] make_request, [1] extra_running, [13:2] extra_ticks_left,
    // [14] tank_filled, [15] zero
    output logic [15:0]                     o_m_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [ctcc_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ctcc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CNT_W = $clog2(CHECK_TICKS + 2);

    ctcc_pkg::t_cfg    r_cfg;
    ctcc_pkg::t_sample r_sample;
    logic              r_in_valid;
    ctcc_pkg::t_state  r_state;
    ctcc_pkg::t_state  n_state;
    logic [CNT_W-1:0]  r_check_cnt;
    logic [CNT_W-1:0]  n_check_cnt;
    logic              r_out_valid;
    logic [15:0]       r_out_data;
    logic              s_xfer;
    logic              advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.make_enable       <= ctcc_pkg::MAKE_ENABLE_RST;
            r_cfg.on_temp           <= ctcc_pkg::ON_TEMP_RST;
            r_cfg.off_temp          <= ctcc_pkg::OFF_TEMP_RST;
            r_cfg.protect_temp      <= ctcc_pkg::PROTECT_TEMP_RST;
            r_cfg.hot_threshold     <= ctcc_pkg::HOT_THRESH_RST;
            r_cfg.warm_threshold    <= ctcc_pkg::WARM_THRESH_RST;
            r_cfg.long_extra_ticks  <= ctcc_pkg::LONG_TICKS_RST;
            r_cfg.short_extra_ticks <= ctcc_pkg::SHORT_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (ctcc_pkg::t_cfg_idx'(i_cfg_addr))
                ctcc_pkg::CFG_MAKE_ENABLE:  r_cfg.make_enable       <= i_cfg_wdata[0];
                ctcc_pkg::CFG_ON_TEMP:      r_cfg.on_temp           <= i_cfg_wdata;
                ctcc_pkg::CFG_OFF_TEMP:     r_cfg.off_temp          <= i_cfg_wdata;
                ctcc_pkg::CFG_PROTECT_TEMP: r_cfg.protect_temp      <= i_cfg_wdata;
                ctcc_pkg::CFG_HOT_THRESH:   r_cfg.hot_threshold     <= i_cfg_wdata;
                ctcc_pkg::CFG_WARM_THRESH:  r_cfg.warm_threshold    <= i_cfg_wdata;
                ctcc_pkg::CFG_LONG_TICKS:   r_cfg.long_extra_ticks  <= i_cfg_wdata;
                ctcc_pkg::CFG_SHORT_TICKS:  r_cfg.short_extra_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Hold the sample until the update stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_sample <= ctcc_pkg::t_sample'(i_s_tdata[17:0]);
        end
    end

    ctcc_step #(
        .CHECK_TICKS(CHECK_TICKS)
    ) u_step (
        .i_cfg       (r_cfg),
        .i_sample    (r_sample),
        .i_state     (r_state),
        .i_check_cnt (r_check_cnt),
        .o_state     (n_state),
        .o_check_cnt (n_check_cnt)
    );

    // Advance state and result together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_check_cnt <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_check_cnt <= n_check_cnt;
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {1'b0, n_state.filled_flag, n_state.extra_count,
                           n_state.extra_phase, n_state.making};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

[rtl/ctcc_checker.sv]
// Port-level checks for cold_tank_chill_control_core, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    logic out_stall;
    logic out_xfer;

    assign out_stall = o_m_tvalid && !i_m_tready;
    assign out_xfer  = o_m_tvalid && i_m_tready;

    `ASSERT_NEXT(a_out_hold, out_stall, o_m_tvalid && $stable(o_m_tdata))
    `ASSERT_NEXT_ALWAYS(a_rst_idle, !i_rst_n, !o_m_tvalid)
    `ASSERT_SAME(a_extra_makes, o_m_tvalid && (o_m_tdata[13:2] != 12'd0), o_m_tdata[0])
    `ASSERT_NEXT(a_filled_sticky, out_xfer && o_m_tdata[14], !o_m_tvalid || o_m_tdata[14])

endmodule

bind cold_tank_chill_control_core ctcc_checker u_ctcc_checker (.*);

[tb/sv/cold_tank_chill_control_core_test.sv]
// Self-checking bench for cold_tank_chill_control_core: streams tank samples, checks each decision.
// Needs ctcc_pkg and the core RTL; predicts chill request, extra run, countdown and fill flag.
`timescale 1ns / 1ps

module cold_tank_chill_control_core_test;

    localparam int CHECK_TICKS = ctcc_pkg::CHECK_TICKS_DEF;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_pattern_e;
    typedef enum int {SEG_WARM, SEG_COOL, SEG_SUBCOOL, SEG_MID, SEG_NOISE} segment_e;

    class chill_scoreboard;
        ctcc_pkg::t_cfg   regs;
        logic             making;
        logic             extra_phase;
        logic             filled;
        logic [11:0]      extra_left;
        logic [7:0]       check_ticks;
        ctcc_pkg::t_state decision_q[$];
        int               n_samples;
        int               n_results;
        int               n_errors;
        int               n_requests;
        int               n_extra;

        function new();
            regs.make_enable       = ctcc_pkg::MAKE_ENABLE_RST;
            regs.on_temp           = ctcc_pkg::ON_TEMP_RST;
            regs.off_temp          = ctcc_pkg::OFF_TEMP_RST;
            regs.protect_temp      = ctcc_pkg::PROTECT_TEMP_RST;
            regs.hot_threshold     = ctcc_pkg::HOT_THRESH_RST;
            regs.warm_threshold    = ctcc_pkg::WARM_THRESH_RST;
            regs.long_extra_ticks  = ctcc_pkg::LONG_TICKS_RST;
            regs.short_extra_ticks = ctcc_pkg::SHORT_TICKS_RST;
            making      = 1'b0;
            extra_phase = 1'b0;
            filled      = 1'b0;
            extra_left  = '0;
            check_ticks = '0;
        endfunction

        function void write_reg(ctcc_pkg::t_cfg_idx idx, logic [11:0] val);
            case (idx)
                ctcc_pkg::CFG_MAKE_ENABLE:  regs.make_enable       = val[0];
                ctcc_pkg::CFG_ON_TEMP:      regs.on_temp           = val;
                ctcc_pkg::CFG_OFF_TEMP:     regs.off_temp          = val;
                ctcc_pkg::CFG_PROTECT_TEMP: regs.protect_temp      = val;
                ctcc_pkg::CFG_HOT_THRESH:   regs.hot_threshold     = val;
                ctcc_pkg::CFG_WARM_THRESH:  regs.warm_threshold    = val;
                ctcc_pkg::CFG_LONG_TICKS:   regs.long_extra_ticks  = val;
                ctcc_pkg::CFG_SHORT_TICKS:  regs.short_extra_ticks = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return decision_q.size();
        endfunction

        function void note_sample(ctcc_pkg::t_sample s);
            logic               mk;
            logic signed [11:0] t;
            ctcc_pkg::t_state   d;
            t = s.temperature;
            n_samples++;
            if (s.level_full) filled = 1'b1;
            if (s.compressor_running && extra_phase) begin
                if (extra_left != 0) extra_left = extra_left - 1'b1;
                else check_ticks = '0;
            end
            mk = extra_phase ? 1'b0 : making;
            if (mk) begin
                if ($signed(regs.off_temp) >= t) begin
                    extra_phase = 1'b1;
                    mk = 1'b0;
                end
                if (check_ticks < CHECK_TICKS) begin
                    check_ticks = check_ticks + 1'b1;
                end else if (check_ticks == CHECK_TICKS) begin
                    check_ticks = check_ticks + 1'b1;
                    if (t > $signed(regs.hot_threshold)) extra_left = regs.long_extra_ticks;
                    else if (t > $signed(regs.warm_threshold)) extra_left = regs.short_extra_ticks;
                    else extra_left = '0;
                end
            end else if ($signed(regs.on_temp) <= t) begin
                mk = 1'b1;
            end
            if (extra_left != 0) begin
                mk = 1'b1;
                if (t <= $signed(regs.protect_temp)) begin
                    mk = 1'b0;
                    extra_left = '0;
                    check_ticks = '0;
                end
            end else begin
                extra_phase = 1'b0;
            end
            if (!regs.make_enable || !filled || !s.protect_time_expired || s.on_time_over ||
                s.second_on_time_over || s.cold_error) begin
                mk = 1'b0;
                extra_left = '0;
                check_ticks = '0;
            end
            making = mk;
            d.making      = making;
            d.extra_phase = extra_phase;
            d.extra_count = extra_left;
            d.filled_flag = filled;
            if (d.making) n_requests++;
            if (d.extra_phase) n_extra++;
            decision_q.push_back(d);
        endfunction

        function void flag_error(string msg);
            n_errors++;
            if (n_errors <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_result(logic [15:0] bits);
            ctcc_pkg::t_state got;
            ctcc_pkg::t_state want;
            got.making      = bits[0];
            got.extra_phase = bits[1];
            got.extra_count = bits[13:2];
            got.filled_flag = bits[14];
            n_results++;
            if (decision_q.size() == 0) begin
                flag_error($sformatf("decision %0d arrived with none expected (data %h)",
                                     n_results, bits));
                return;
            end
            want = decision_q.pop_front();
            if (got.making !== want.making || got.extra_phase !== want.extra_phase ||
                got.extra_count !== want.extra_count || got.filled_flag !== want.filled_flag)
                flag_error($sformatf({"decision %0d exp req=%0b extra=%0b left=%0d filled=%0b",
                                      " got req=%0b extra=%0b left=%0d filled=%0b"},
                                     n_results, want.making, want.extra_phase,
                                     want.extra_count, want.filled_flag, got.making,
                                     got.extra_phase, got.extra_count, got.filled_flag));
        endfunction

        function void close_out();
            if (decision_q.size() != 0)
                flag_error($sformatf("%0d decisions never arrived", decision_q.size()));
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [23:0]                     i_s_tdata;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [15:0]                     o_m_tdata;
    logic                            i_cfg_wr_en;
    logic [ctcc_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [ctcc_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    chill_scoreboard sb;
    int              cycle_count = 0;
    int              burst_left = 0;
    bit              flood = 1'b0;
    rx_pattern_e     rx_pattern = RX_OPEN;
    int              rx_left = 0;

    cold_tank_chill_control_core #(
        .CHECK_TICKS(CHECK_TICKS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver backpressure: pick a new random pattern whenever the hold counter runs out.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_pattern <= rx_pattern_e'($urandom_range(3));
            rx_left    <= $urandom_range(20, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_pattern)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_COIN:   i_m_tready <= $urandom_range(1);
            RX_MOSTLY: i_m_tready <= ($urandom_range(4) != 0);
            default:   i_m_tready <= (cycle_count % 4 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    function automatic int rand_between(int lo, int hi);
        int t;
        if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic logic signed [11:0] to_temp(int v);
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return v[11:0];
    endfunction

    function automatic ctcc_pkg::t_sample make_sample(int t, bit comp, bit level, bit rest,
                                                      bit over1, bit over2, bit err);
        ctcc_pkg::t_sample s;
        s.temperature          = to_temp(t);
        s.compressor_running   = comp;
        s.level_full           = level;
        s.protect_time_expired = rest;
        s.on_time_over         = over1;
        s.second_on_time_over  = over2;
        s.cold_error           = err;
        return s;
    endfunction

    // Normal operating flags, with an occasional protection fault.
    function automatic ctcc_pkg::t_sample healthy(int t, bit comp);
        ctcc_pkg::t_sample s;
        s = make_sample(t, comp, $urandom_range(7) != 0, 1'b1, 1'b0, 1'b0, 1'b0);
        if ($urandom_range(39) == 0) begin
            case ($urandom_range(3))
                0: s.protect_time_expired = 1'b0;
                1: s.on_time_over = 1'b1;
                2: s.second_on_time_over = 1'b1;
                default: s.cold_error = 1'b1;
            endcase
        end
        return s;
    endfunction

    task automatic push_sample(input ctcc_pkg::t_sample s);
        int gap;
        if (burst_left == 0) begin
            gap = flood ? 0 : (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6));
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, s.cold_error, s.second_on_time_over, s.on_time_over,
                       s.protect_time_expired, s.level_full, s.compressor_running,
                       s.temperature};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_sample(s);
        burst_left--;
    endtask

    // Hold off the sender until every decision is back, then let the pipeline settle.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_setting(input int en, input int on, input int off, input int prot,
                                input int hot, input int warm, input int lng, input int sht);
        int          vals[8];
        int          i;
        logic [11:0] v;
        vals = '{en, on, off, prot, hot, warm, lng, sht};
        for (i = 0; i < 8; i++) begin
            v = vals[i][11:0];
            i_cfg_wr_en <= 1'b1;
            i_cfg_addr  <= ctcc_pkg::t_cfg_idx'(i);
            i_cfg_wdata <= v;
            @(posedge i_clk);
            sb.write_reg(ctcc_pkg::t_cfg_idx'(i), v);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly chill cycles: warm-up runs that can pass the check point, cool-down into the
    // extra run, sub-cool cuts, mid-band stretches, plus noise with arbitrary flags and temperatures.
    task automatic run_random(input int count);
        int                sent;
        int                len;
        int                pick;
        int                i;
        int                t;
        int                anchor;
        int                on_t;
        int                off_t;
        int                prot_t;
        int                hot_t;
        int                warm_t;
        segment_e          seg;
        ctcc_pkg::t_sample s;
        logic [17:0]       raw;
        sent  = 0;
        flood = ($urandom_range(3) == 0);
        while (sent < count) begin
            on_t   = $signed(sb.regs.on_temp);
            off_t  = $signed(sb.regs.off_temp);
            prot_t = $signed(sb.regs.protect_temp);
            hot_t  = $signed(sb.regs.hot_threshold);
            warm_t = $signed(sb.regs.warm_threshold);
            pick   = $urandom_range(99);
            if (pick < 30) seg = SEG_WARM;
            else if (pick < 60) seg = SEG_COOL;
            else if (pick < 70) seg = SEG_SUBCOOL;
            else if (pick < 85) seg = SEG_MID;
            else seg = SEG_NOISE;
            case (seg)
                SEG_WARM:    len = $urandom_range(40, 75);
                SEG_COOL:    len = $urandom_range(3, 30);
                SEG_SUBCOOL: len = $urandom_range(1, 4);
                default:     len = $urandom_range(1, 8);
            endcase
            for (i = 0; i < len && sent < count; i++) begin
                case (seg)
                    SEG_WARM: begin
                        if (i == 0) begin
                            s = healthy(rand_between(on_t, (on_t > 1250) ? on_t : 1250), 1'b1);
                        end else begin
                            case ($urandom_range(3))
                                0: anchor = on_t;
                                1: anchor = warm_t;
                                2: anchor = hot_t;
                                default: anchor = 1000;
                            endcase
                            t = rand_between(anchor - 60, anchor + 60);
                            if (t <= off_t) t = off_t + 1;
                            s = healthy(t, $urandom_range(9) != 0);
                        end
                    end
                    SEG_COOL:    s = healthy(rand_between(prot_t + 1, off_t),
                                             $urandom_range(9) != 0);
                    SEG_SUBCOOL: s = healthy(rand_between(prot_t - 100, prot_t),
                                             $urandom_range(1));
                    SEG_MID:     s = healthy(rand_between(off_t + 1, on_t - 1),
                                             $urandom_range(1));
                    default: begin
                        raw = 18'($urandom);
                        s = ctcc_pkg::t_sample'(raw);
                    end
                endcase
                push_sample(s);
                sent++;
            end
        end
    endtask

    initial begin
        int phase;
        int on_t;
        int off_t;
        sb = new();
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_wdata <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_sample(make_sample(0, 0, 0, 1, 0, 0, 0));
        push_sample(make_sample(1250, 1, 0, 1, 0, 0, 0));
        push_sample(make_sample(1250, 1, 1, 1, 0, 0, 0));
        push_sample(make_sample(2047, 1, 1, 1, 0, 0, 0));
        push_sample(make_sample(-2048, 1, 0, 1, 0, 0, 0));
        push_sample(make_sample(-400, 0, 0, 1, 0, 0, 0));
        push_sample(make_sample(1250, 1, 1, 0, 0, 0, 0));
        push_sample(make_sample(1250, 1, 1, 1, 1, 0, 0));
        push_sample(make_sample(1250, 1, 1, 1, 0, 1, 0));
        push_sample(make_sample(1250, 1, 1, 1, 0, 0, 1));
        push_sample(make_sample(68, 1, 1, 1, 0, 0, 0));
        push_sample(make_sample(46, 1, 1, 1, 0, 0, 0));
        push_sample(make_sample(45, 1, 1, 1, 0, 0, 0));
        push_sample(make_sample(67, 0, 1, 1, 0, 0, 0));
        push_sample(make_sample(0, 1, 1, 1, 0, 0, 0));
        push_sample(make_sample(-1, 0, 0, 1, 1, 1, 1));
        push_sample(make_sample(1, 1, 1, 0, 1, 1, 1));
        push_sample(make_sample(2047, 1, 1, 1, 0, 0, 0));
        run_random(100);
        drain();

        for (phase = 1; phase <= 6; phase++) begin
            case (phase)
                1: load_setting(1, 68, 45, 0, 300, 150, 7, 3);
                2: load_setting(1, 1250, -400, -400, 1250, -400, 4095, 0);
                3: load_setting(1, -400, 1250, 1250, -400, 1250, 0, 4095);
                4: load_setting(0, 68, 45, 0, 300, 150, 20, 10);
                default: begin
                    on_t  = rand_between(-300, 1200);
                    off_t = on_t - rand_between(0, 120);
                    load_setting(1, on_t, off_t, off_t - rand_between(0, 150),
                                 rand_between(150, 1250), rand_between(-400, 150),
                                 rand_between(0, (phase == 5) ? 30 : 200),
                                 rand_between(0, (phase == 5) ? 30 : 200));
                end
            endcase
            run_random(115);
            drain();
        end

        repeat (8) @(posedge i_clk);
        sb.close_out();
        $display("tb: %0d samples over 7 register settings, %0d decisions checked",
                 sb.n_samples, sb.n_results);
        $display("tb: %0d with chilling requested, %0d in extra run, %0d mismatches",
                 sb.n_requests, sb.n_extra, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ctcc_pkg.sv
rtl/ctcc_step.sv
rtl/cold_tank_chill_control_core.sv
rtl/ctcc_checker.sv
tb/sv/cold_tank_chill_control_core_test.sv
